@@ rtl/core/go_back_n_block_sender_unit_macros.svh @@
// Assertion macros used by the go-back-N sender control RTL.
`ifndef GO_BACK_N_BLOCK_SENDER_UNIT_MACROS_SVH
`define GO_BACK_N_BLOCK_SENDER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define GBN_ASSERT_HOLD(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbn: same-cycle check failed");

// Next-cycle implication, clocked on clk, disabled in reset.
`define GBN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbn: next-cycle check failed");

`endif

@@ rtl/core/gbn_pkg.sv @@
// Types, codes and constants of the go-back-N block sender.
package gbn_pkg;

  localparam int unsigned WINDOW_DEF = 16;
  localparam int unsigned BLK_W      = 16;
  localparam int unsigned RETRY_W    = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [BLK_W-1:0]   LAST_BLOCK_RST  = 16'd1;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 8'd20;
  localparam logic [BLK_W-1:0]   FIRST_BLOCK     = 16'd1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_ABORT   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_NEW    = 3'd0,
    KIND_RESEND = 3'd1,
    KIND_DONE   = 3'd2,
    KIND_FAIL   = 3'd3,
    KIND_ABORT  = 3'd4
  } kind_t;

  typedef enum logic {
    REG_LAST_BLOCK  = 1'b0,
    REG_MAX_RETRIES = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_WAIT,
    S_FILL,
    S_RESEND,
    S_STATUS
  } seq_state_t;

  typedef struct packed {
    logic [BLK_W-1:0]   last_block;
    logic [RETRY_W-1:0] max_retries;
  } cfg_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk_inc;
    logic             is_final;
    logic             inc_is_end;
    logic             span_ok;
    logic             inc_span_ok;
  } blk_step_t;

endpackage

@@ rtl/core/gbn_cfg_regs.sv @@
// APB-style configuration registers: last block number and retry limit.
module gbn_cfg_regs import gbn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Decode the write request
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_LAST_BLOCK:  cfg_nxt.last_block  = pwdata[BLK_W-1:0];
        REG_MAX_RETRIES: cfg_nxt.max_retries = pwdata[RETRY_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.last_block  <= LAST_BLOCK_RST;
      cfg_r.max_retries <= MAX_RETRIES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      REG_LAST_BLOCK:  prdata = {{(CFG_DATA_W-BLK_W){1'b0}}, cfg_r.last_block};
      REG_MAX_RETRIES: prdata = {{(CFG_DATA_W-RETRY_W){1'b0}}, cfg_r.max_retries};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/gbn_blk_unit.sv @@
// Shared block-number unit: increment, final match and window span checks.
module gbn_blk_unit import gbn_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic [BLK_W-1:0] cur_blk,
  input  logic [BLK_W-1:0] base_blk,
  input  logic [BLK_W-1:0] end_blk,
  input  logic [BLK_W-1:0] last_block,
  output blk_step_t        step
);

  localparam logic [BLK_W-1:0] WIN = BLK_W'(WINDOW);

  logic [BLK_W-1:0] inc;
  logic [BLK_W-1:0] span;
  logic [BLK_W-1:0] inc_span;

  // Spans are taken modulo 2^16 so the window may wrap
  assign inc      = cur_blk + 16'd1;
  assign span     = cur_blk - base_blk;
  assign inc_span = inc - base_blk;

  assign step.blk_inc     = inc;
  assign step.is_final    = (cur_blk == last_block);
  assign step.inc_is_end  = (inc == end_blk);
  assign step.span_ok     = (span < WIN);
  assign step.inc_span_ok = (inc_span < WIN);

endmodule

@@ rtl/core/gbn_ctrl.sv @@
// Window sequencer: decodes requests, walks blocks and holds the result register.
module gbn_ctrl import gbn_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  input  logic [BLK_W-1:0] in_ack_block,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_kind,
  output logic [BLK_W-1:0] out_block_number,
  output logic             out_final_block,
  output logic             out_last
);

  `include "go_back_n_block_sender_unit_macros.svh"

  seq_state_t         state_r, state_nxt;
  logic               run_r, run_nxt;
  logic [BLK_W-1:0]   base_r, base_nxt;
  logic [BLK_W-1:0]   next_r, next_nxt;
  logic [BLK_W-1:0]   walk_r, walk_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;
  logic               final_sent_r, final_sent_nxt;
  logic               fail_r, fail_nxt;
  kind_t              status_kind_r, status_kind_nxt;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [BLK_W-1:0]   out_block_r;
  logic               out_final_r;
  logic               out_last_r;

  logic               emit;
  kind_t              e_kind;
  logic [BLK_W-1:0]   e_blk;
  logic               e_fin;
  logic               e_last;

  op_t                op;
  logic               accept;
  logic               space;
  logic [BLK_W-1:0]   ack_off;
  logic [BLK_W-1:0]   outst;
  logic               ack_hit;
  logic [RETRY_W-1:0] rc_inc;
  logic               fail_now;
  logic               win_empty;
  logic [BLK_W-1:0]   cur_blk;
  blk_step_t          step;
  logic               fill_ok;
  logic               fin_after;
  logic               fill_more;

  // Request decode terms
  assign op        = op_t'(in_operation);
  assign in_ready  = (state_r == S_WAIT);
  assign accept    = in_valid && in_ready;
  assign space     = !out_valid_r || out_ready;
  assign ack_off   = in_ack_block - base_r;
  assign outst     = next_r - base_r;
  assign ack_hit   = (ack_off < outst);
  assign rc_inc    = (retry_r != {RETRY_W{1'b1}}) ? retry_r + 8'd1 : retry_r;
  assign fail_now  = (rc_inc >= cfg.max_retries);
  assign win_empty = (base_r == next_r);

  // Shared block unit walks next_r while filling and walk_r while resending
  assign cur_blk = (state_r == S_RESEND) ? walk_r : next_r;

  gbn_blk_unit #(
    .WINDOW(WINDOW)
  ) u_blk_unit (
    .cur_blk   (cur_blk),
    .base_blk  (base_r),
    .end_blk   (next_r),
    .last_block(cfg.last_block),
    .step      (step)
  );

  assign fill_ok   = !final_sent_r && step.span_ok;
  assign fin_after = final_sent_r || step.is_final;
  assign fill_more = !fin_after && step.inc_span_ok;

  // Datapath updates and result emission
  always_comb begin
    emit            = 1'b0;
    e_kind          = KIND_NEW;
    e_blk           = '0;
    e_fin           = 1'b0;
    e_last          = 1'b0;
    run_nxt         = run_r;
    base_nxt        = base_r;
    next_nxt        = next_r;
    walk_nxt        = walk_r;
    retry_nxt       = retry_r;
    final_sent_nxt  = final_sent_r;
    fail_nxt        = fail_r;
    status_kind_nxt = status_kind_r;
    case (state_r)
      S_WAIT: begin
        if (accept) begin
          case (op)
            OP_START: begin
              base_nxt       = FIRST_BLOCK;
              next_nxt       = FIRST_BLOCK;
              retry_nxt      = '0;
              final_sent_nxt = 1'b0;
              run_nxt        = 1'b1;
            end
            OP_ACK: begin
              if (run_r && ack_hit) begin
                base_nxt  = in_ack_block + 16'd1;
                retry_nxt = '0;
              end
            end
            OP_TIMEOUT: begin
              if (run_r) begin
                retry_nxt       = rc_inc;
                fail_nxt        = fail_now;
                walk_nxt        = base_r;
                status_kind_nxt = KIND_FAIL;
              end
            end
            OP_ABORT: begin
              if (run_r) begin
                status_kind_nxt = KIND_ABORT;
              end
            end
            default: begin
              run_nxt = run_r;
            end
          endcase
        end
      end
      S_FILL: begin
        if (fill_ok) begin
          if (space) begin
            emit           = 1'b1;
            e_kind         = KIND_NEW;
            e_blk          = next_r;
            e_fin          = step.is_final;
            e_last         = !fill_more;
            next_nxt       = step.blk_inc;
            final_sent_nxt = fin_after;
          end
        end else begin
          status_kind_nxt = KIND_DONE;
        end
      end
      S_RESEND: begin
        if (space) begin
          emit     = 1'b1;
          e_kind   = KIND_RESEND;
          e_blk    = walk_r;
          e_fin    = step.is_final;
          e_last   = step.inc_is_end && !fail_r;
          walk_nxt = step.blk_inc;
        end
      end
      S_STATUS: begin
        if (space) begin
          emit    = 1'b1;
          e_kind  = status_kind_r;
          e_last  = 1'b1;
          run_nxt = 1'b0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_WAIT: begin
        if (accept) begin
          case (op)
            OP_START: state_nxt = S_FILL;
            OP_ACK: begin
              if (run_r && ack_hit) begin
                state_nxt = S_FILL;
              end
            end
            OP_TIMEOUT: begin
              if (run_r) begin
                if (!win_empty) begin
                  state_nxt = S_RESEND;
                end else if (fail_now) begin
                  state_nxt = S_STATUS;
                end
              end
            end
            OP_ABORT: begin
              if (run_r) begin
                state_nxt = S_STATUS;
              end
            end
            default: state_nxt = S_WAIT;
          endcase
        end
      end
      S_FILL: begin
        if (fill_ok) begin
          if (space && !fill_more) begin
            state_nxt = S_WAIT;
          end
        end else if (win_empty) begin
          state_nxt = S_STATUS;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_RESEND: begin
        if (space && step.inc_is_end) begin
          state_nxt = fail_r ? S_STATUS : S_WAIT;
        end
      end
      S_STATUS: begin
        if (space) begin
          state_nxt = S_WAIT;
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

  // Control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_WAIT;
      run_r        <= 1'b0;
      base_r       <= FIRST_BLOCK;
      next_r       <= FIRST_BLOCK;
      retry_r      <= '0;
      final_sent_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_r        <= run_nxt;
      base_r       <= base_nxt;
      next_r       <= next_nxt;
      retry_r      <= retry_nxt;
      final_sent_r <= final_sent_nxt;
      out_valid_r  <= emit || (out_valid_r && !out_ready);
    end
  end

  // Walk pointer, pending status and result payload
  always_ff @(posedge clk) begin
    walk_r        <= walk_nxt;
    fail_r        <= fail_nxt;
    status_kind_r <= status_kind_nxt;
    if (emit) begin
      out_kind_r  <= e_kind;
      out_block_r <= e_blk;
      out_final_r <= e_fin;
      out_last_r  <= e_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_block_number = out_block_r;
  assign out_final_block  = out_final_r;
  assign out_last         = out_last_r;

  `GBN_ASSERT_HOLD(a_busy_needs_run, state_r != S_WAIT, run_r)
  `GBN_ASSERT_HOLD(a_open_window_nonempty, run_r && state_r == S_WAIT, next_r != base_r)
  `GBN_ASSERT_NEXT(a_status_ends_run, state_r == S_STATUS && space, !run_r)
  `GBN_ASSERT_NEXT(a_last_returns_idle, emit && e_last, state_r == S_WAIT)

endmodule

@@ rtl/core/go_back_n_block_sender_unit.sv @@
// Top level of the go-back-N block sender window controller.
//
//  channel  direction  handshake              payload
//  in_      request    in_valid / in_ready    in_operation, in_ack_block
//  out_     result     out_valid / out_ready  out_kind, out_block_number,
//                                             out_final_block, out_last
//  cfg      APB r/w    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// A request is taken while in_ready is high; a small sequencer then loads one
// result per cycle, holding while the output stalls, into the output register
// through the shared block unit: start and ack send new blocks (ack a done
// status on completion), timeout resends outstanding blocks (a fail status on
// failure), abort an abort status. in_ready is low until the sequencer is idle
// again. Reset is synchronous on rst_n: idle, window at block 1.
module go_back_n_block_sender_unit import gbn_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  logic [BLK_W-1:0]      in_ack_block,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_kind,
  output logic [BLK_W-1:0]      out_block_number,
  output logic                  out_final_block,
  output logic                  out_last
);

  cfg_t cfg;

  gbn_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  gbn_ctrl #(
    .WINDOW(WINDOW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_ack_block    (in_ack_block),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_block_number(out_block_number),
    .out_final_block (out_final_block),
    .out_last        (out_last)
  );

endmodule
